FILE: rtl/desp_pkg.sv
// Shared types and constants for the directory entry stream parser.
package desp_pkg;

   localparam int MAX_CHUNK_BYTES_DEFAULT = 65536;

   localparam int DATA_W   = 8;
   localparam int CHUNK_W  = 17;
   localparam int INODE_W  = 32;
   localparam int RECLEN_W = 16;

   localparam logic [RECLEN_W-1:0] HEADER_BYTES = 16'd8;
   localparam logic [1:0]          ALIGN_MASK   = 2'd3;

   localparam logic [RECLEN_W-1:0] OFF_INODE_LO = 16'd0;
   localparam logic [RECLEN_W-1:0] OFF_INODE_HI = 16'd3;
   localparam logic [RECLEN_W-1:0] OFF_RECLEN_LO = 16'd4;
   localparam logic [RECLEN_W-1:0] OFF_RECLEN_HI = 16'd5;
   localparam logic [RECLEN_W-1:0] OFF_NAME_LEN = 16'd6;
   localparam logic [RECLEN_W-1:0] OFF_FILE_TYPE = 16'd7;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_SHORT_TAIL  = 2'd1,
      ERR_BAD_RECLEN  = 2'd2,
      ERR_NAME_LENGTH = 2'd3
   } error_kind_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data_byte;
      logic [CHUNK_W-1:0] chunk_bytes;
      logic               walk_start;
   } req_payload_type;

   typedef struct packed {
      logic [INODE_W-1:0] entry_inode;
      logic [7:0]         entry_type;
      logic [7:0]         name_length;
      logic [7:0]         name_byte;
      logic [7:0]         name_index;
      logic               last_of_name;
      error_kind_type     error_kind;
   } rsp_payload_type;

endpackage

FILE: rtl/desp_in_stage.sv
// Input register that holds one request beat until the parser takes it.
module desp_in_stage
   import desp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic            advance,
   output logic            item_valid,
   output req_payload_type item_data
);

   logic            valid_ff, valid_in;
   req_payload_type data_ff, data_in;

   always_comb begin
      req_ready = !valid_ff || advance;
      valid_in  = valid_ff;
      data_in   = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

FILE: rtl/desp_parser.sv
// Record field capture, validity checks and name byte selection for one beat.
module desp_parser
   import desp_pkg::*;
#(
   parameter int MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type item,
   input  logic            filetype_enabled,
   output logic            produce,
   output rsp_payload_type result
);

   localparam int POS_W = $clog2(MAX_CHUNK_BYTES + 1);
   localparam logic [CHUNK_W-1:0] MAX_AMOUNT = CHUNK_W'(MAX_CHUNK_BYTES);

   logic [POS_W-1:0]    position_ff, position_in;
   logic [RECLEN_W-1:0] offset_ff, offset_in;
   logic [RECLEN_W-1:0] reclen_ff, reclen_in;
   logic [INODE_W-1:0]  inode_ff, inode_in;
   logic [7:0]          name_count_ff, name_count_in;
   logic [7:0]          type_ff, type_in;
   logic                halted_ff, halted_in;

   logic [CHUNK_W-1:0]  amount;
   logic [CHUNK_W-1:0]  pos;
   logic [RECLEN_W-1:0] off;
   logic                halted_eff;
   logic [CHUNK_W-1:0]  left;
   logic [CHUNK_W-1:0]  start;
   logic [CHUNK_W:0]    room;
   logic [RECLEN_W-1:0] reclen_full;
   logic                reclen_bad;
   logic [RECLEN_W-1:0] idx;
   logic [CHUNK_W-1:0]  next_off;
   logic [CHUNK_W-1:0]  pos_inc;
   logic                error_hit;
   error_kind_type      error_code;

   always_comb begin
      amount = item.chunk_bytes;
      if (amount == '0) begin
         amount = CHUNK_W'(1);
      end else if (amount > MAX_AMOUNT) begin
         amount = MAX_AMOUNT;
      end

      pos        = CHUNK_W'(position_ff);
      off        = offset_ff;
      halted_eff = halted_ff;
      if (item.walk_start) begin
         pos        = '0;
         off        = '0;
         halted_eff = 1'b0;
      end

      left        = (amount > pos) ? (amount - pos) : '0;
      start       = pos - CHUNK_W'(off);
      room        = {1'b0, amount} - {1'b0, start};
      reclen_full = {item.data_byte, reclen_ff[7:0]};
      reclen_bad  = (reclen_full < HEADER_BYTES) || ((reclen_full[1:0] & ALIGN_MASK) != 2'd0)
                    || (!room[CHUNK_W] && (CHUNK_W'(reclen_full) > room[CHUNK_W-1:0]));
      idx         = off - HEADER_BYTES;

      position_in   = position_ff;
      offset_in     = offset_ff;
      reclen_in     = reclen_ff;
      inode_in      = inode_ff;
      name_count_in = name_count_ff;
      type_in       = type_ff;
      halted_in     = halted_ff;
      error_hit     = 1'b0;
      error_code    = ERR_NONE;
      next_off      = '0;
      pos_inc       = '0;
      produce       = 1'b0;
      result        = '0;

      if (fire) begin
         position_in = POS_W'(pos);
         offset_in   = off;
         halted_in   = halted_eff;
         if (!halted_eff) begin
            priority if (off == OFF_INODE_LO) begin
               if (left < CHUNK_W'(HEADER_BYTES)) begin
                  error_hit  = 1'b1;
                  error_code = ERR_SHORT_TAIL;
               end else begin
                  inode_in = INODE_W'(item.data_byte);
               end
            end else if (off <= OFF_INODE_HI) begin
               inode_in = inode_ff | (INODE_W'(item.data_byte) << {off[1:0], 3'b000});
            end else if (off == OFF_RECLEN_LO) begin
               reclen_in = RECLEN_W'(item.data_byte);
            end else if (off == OFF_RECLEN_HI) begin
               reclen_in = reclen_full;
               if (reclen_bad) begin
                  error_hit  = 1'b1;
                  error_code = ERR_BAD_RECLEN;
               end
            end else if (off == OFF_NAME_LEN) begin
               name_count_in = item.data_byte;
               if (RECLEN_W'(item.data_byte) > (reclen_ff - HEADER_BYTES)) begin
                  error_hit  = 1'b1;
                  error_code = ERR_NAME_LENGTH;
               end
            end else if (off == OFF_FILE_TYPE) begin
               type_in = filetype_enabled ? item.data_byte : 8'd0;
            end else begin
               if ((idx < RECLEN_W'(name_count_ff)) && (inode_ff != '0)
                     && (name_count_ff != 8'd0)) begin
                  produce             = 1'b1;
                  result.entry_inode  = inode_ff;
                  result.entry_type   = type_ff;
                  result.name_length  = name_count_ff;
                  result.name_byte    = item.data_byte;
                  result.name_index   = idx[7:0];
                  result.last_of_name = ((idx + 16'd1) == RECLEN_W'(name_count_ff));
                  result.error_kind   = ERR_NONE;
               end
            end

            if (error_hit) begin
               produce           = 1'b1;
               result            = '0;
               result.error_kind = error_code;
               halted_in         = 1'b1;
            end else begin
               next_off = CHUNK_W'(off) + CHUNK_W'(1);
               if ((next_off >= CHUNK_W'(HEADER_BYTES)) && (next_off >= CHUNK_W'(reclen_in))) begin
                  next_off = '0;
               end
               offset_in = next_off[RECLEN_W-1:0];
               pos_inc   = pos + CHUNK_W'(1);
               if (pos_inc >= amount) begin
                  position_in = '0;
                  offset_in   = '0;
               end else begin
                  position_in = POS_W'(pos_inc);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         offset_ff     <= '0;
         reclen_ff     <= '0;
         inode_ff      <= '0;
         name_count_ff <= '0;
         type_ff       <= '0;
         halted_ff     <= 1'b0;
      end else begin
         position_ff   <= position_in;
         offset_ff     <= offset_in;
         reclen_ff     <= reclen_in;
         inode_ff      <= inode_in;
         name_count_ff <= name_count_in;
         type_ff       <= type_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

FILE: rtl/desp_out_stage.sv
// Result register that presents one response beat until it is taken.
module desp_out_stage
   import desp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic            load_valid,
   input  rsp_payload_type load_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = load_valid;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/directory_entry_stream_parser_core.sv
// Top level of the directory entry stream parser.
//
//  Channel  Direction  Handshake            Beat contents
//  req      in         req_valid/req_ready  one directory byte, chunk length, walk start
//  rsp      out        rsp_valid/rsp_ready  one name byte with entry fields, or an error
//  csr      in         csr_write_enable     file type enable bit
//
// A byte waits in the input register until the parser takes it, and any response beat it makes is
// visible the cycle after that; one byte is taken every cycle while the response is not stalled.
// The input register refills in the same cycle that the parser consumes it.
// Reset is synchronous and clears the walk position, the halt flag and both stages;
// the file type enable comes out of reset set.
// A stalled response holds the parser and, through it, the input register.
module directory_entry_stream_parser_core
   import desp_pkg::*;
#(
   parameter int MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_enable,
   input  logic            csr_write_data
);

   logic            filetype_ff, filetype_in;
   logic            item_valid;
   req_payload_type item_data;
   logic            advance;
   logic            produce;
   rsp_payload_type result;

   assign filetype_in = csr_write_enable ? csr_write_data : filetype_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filetype_ff <= 1'b1;
      end else begin
         filetype_ff <= filetype_in;
      end
   end

   assign advance = item_valid && (!rsp_valid || rsp_ready);

   desp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   desp_parser #(
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .fire             (advance),
      .item             (item_data),
      .filetype_enabled (filetype_ff),
      .produce          (produce),
      .result           (result)
   );

   desp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (produce),
      .load_data  (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/sv/directory_entry_stream_parser_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the directory entry stream parser, with its scoreboard.

import desp_pkg::*;

class entry_scoreboard;
   rsp_payload_type expected_q[$];
   int unsigned mismatches;
   bit filetype_on;
   int unsigned chunk_pos, rec_off, rec_len, inode_acc, name_cnt, type_val;
   bit halted;

   function new();
      mismatches = 0;
      filetype_on = 1'b1;
      chunk_pos = 0;
      rec_off = 0;
      rec_len = 0;
      inode_acc = 0;
      name_cnt = 0;
      type_val = 0;
      halted = 1'b0;
   endfunction

   function void push_error(error_kind_type kind);
      rsp_payload_type res;
      res = '0;
      res.error_kind = kind;
      expected_q.push_back(res);
      halted = 1'b1;
   endfunction

   // Returns 1 when the parser acts on the beat, 0 when a halted walk drops it.
   function bit note_beat(req_payload_type p);
      int unsigned amount, off, left, base, idx, nxt, b;
      rsp_payload_type res;
      amount = p.chunk_bytes;
      b = p.data_byte;
      if (p.walk_start) begin
         chunk_pos = 0;
         rec_off = 0;
         halted = 1'b0;
      end
      if (halted) return 1'b0;
      if (amount == 0) amount = 1;
      if (amount > MAX_CHUNK_BYTES_DEFAULT) amount = MAX_CHUNK_BYTES_DEFAULT;
      off = rec_off;
      if (off == OFF_INODE_LO) begin
         left = (amount > chunk_pos) ? amount - chunk_pos : 0;
         if (left < HEADER_BYTES) begin
            push_error(ERR_SHORT_TAIL);
            return 1'b1;
         end
         inode_acc = b;
      end else if (off <= OFF_INODE_HI) begin
         inode_acc |= b << (8 * off);
      end else if (off == OFF_RECLEN_LO) begin
         rec_len = b;
      end else if (off == OFF_RECLEN_HI) begin
         rec_len |= b << 8;
         base = chunk_pos - rec_off;
         if (rec_len < HEADER_BYTES || (rec_len & ALIGN_MASK) != 0 || rec_len > amount - base) begin
            push_error(ERR_BAD_RECLEN);
            return 1'b1;
         end
      end else if (off == OFF_NAME_LEN) begin
         name_cnt = b;
         if (name_cnt > rec_len - HEADER_BYTES) begin
            push_error(ERR_NAME_LENGTH);
            return 1'b1;
         end
      end else if (off == OFF_FILE_TYPE) begin
         type_val = filetype_on ? b : 0;
      end else begin
         idx = off - HEADER_BYTES;
         if (idx < name_cnt && inode_acc != 0 && name_cnt != 0) begin
            res.entry_inode = inode_acc;
            res.entry_type = 8'(type_val);
            res.name_length = 8'(name_cnt);
            res.name_byte = p.data_byte;
            res.name_index = 8'(idx);
            res.last_of_name = (idx + 1 == name_cnt);
            res.error_kind = ERR_NONE;
            expected_q.push_back(res);
         end
      end
      nxt = off + 1;
      if (nxt >= HEADER_BYTES && nxt >= rec_len) nxt = 0;
      rec_off = nxt & 16'hFFFF;
      chunk_pos++;
      if (chunk_pos >= amount) begin
         chunk_pos = 0;
         rec_off = 0;
      end
      return 1'b1;
   endfunction

   task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 30) $display("%0t ns mismatch: %s", $time, what);
   endtask

   task check_beat(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("response beat %h with nothing expected", got));
         return;
      end
      want = expected_q.pop_front();
      if (got.entry_inode !== want.entry_inode)
         report_mismatch($sformatf("entry_inode %h, want %h", got.entry_inode, want.entry_inode));
      if (got.entry_type !== want.entry_type)
         report_mismatch($sformatf("entry_type %h, want %h", got.entry_type, want.entry_type));
      if (got.name_length !== want.name_length)
         report_mismatch($sformatf("name_length %0d, want %0d", got.name_length, want.name_length));
      if (got.name_byte !== want.name_byte)
         report_mismatch($sformatf("name_byte %h, want %h", got.name_byte, want.name_byte));
      if (got.name_index !== want.name_index)
         report_mismatch($sformatf("name_index %0d, want %0d", got.name_index, want.name_index));
      if (got.last_of_name !== want.last_of_name)
         report_mismatch($sformatf("last_of_name %b, want %b", got.last_of_name, want.last_of_name));
      if (got.error_kind !== want.error_kind)
         report_mismatch($sformatf("error_kind %s, want %s", got.error_kind.name(),
                                   want.error_kind.name()));
   endtask

   task check_leftovers();
      if (expected_q.size() != 0)
         report_mismatch($sformatf("%0d expected beats never arrived", expected_q.size()));
   endtask
endclass

module directory_entry_stream_parser_core_test;
   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_write_enable;
   logic            csr_write_data;

   entry_scoreboard sb;
   bit              idle_on;
   bit              start_pending;
   int unsigned     parsed_beats;
   int unsigned     target;

   directory_entry_stream_parser_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] random_inode();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic int unsigned chunk_span();
      if ($urandom_range(0, 19) == 0) return 1024;
      return HEADER_BYTES + 4 * $urandom_range(0, 30);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic [16:0] chunk);
      req_payload_type p;
      int unsigned gap;
      bit hold;
      p.data_byte = b;
      p.chunk_bytes = chunk;
      p.walk_start = start_pending;
      start_pending = 1'b0;
      gap = idle_cycles();
      hold = ($urandom_range(0, 199) == 0);
      if (hold && gap == 0) gap = 1;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (hold) begin
            while (sb.expected_q.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      if (sb.note_beat(p)) parsed_beats++;
   endtask

   task automatic send_record(input logic [31:0] inode, input logic [15:0] reclen,
                              input logic [7:0] namelen, input logic [7:0] ftype,
                              input int unsigned body, input logic [16:0] chunk);
      for (int i = 0; i < 4; i++) send_byte(inode[8*i +: 8], chunk);
      send_byte(reclen[7:0], chunk);
      send_byte(reclen[15:8], chunk);
      send_byte(namelen, chunk);
      send_byte(ftype, chunk);
      repeat (body) send_byte($urandom_range(0, 255), chunk);
   endtask

   // Fills span bytes with well-formed records; span is a multiple of 4, at least 8.
   // Stops at a record boundary once the phase has parsed enough beats.
   task automatic fill_chunk(input int unsigned span, input logic [16:0] chunk);
      int unsigned remaining, reclen, kmax, nmax, namelen;
      remaining = span;
      while (remaining >= HEADER_BYTES && parsed_beats < target) begin
         if (remaining >= 272 && $urandom_range(0, 2) == 0) begin
            reclen = 264;
            namelen = 255;
         end else begin
            kmax = (remaining - HEADER_BYTES) / 4;
            if (kmax > 10) kmax = 10;
            reclen = HEADER_BYTES + 4 * $urandom_range(0, kmax);
            if (remaining - reclen < HEADER_BYTES) reclen = remaining;
            nmax = reclen - HEADER_BYTES;
            if (nmax > 255) nmax = 255;
            namelen = $urandom_range(0, nmax);
         end
         send_record(random_inode(), reclen, namelen, $urandom_range(0, 255),
                     reclen - HEADER_BYTES, chunk);
         remaining -= reclen;
      end
   endtask

   task automatic good_walk();
      int unsigned chunks, span, last;
      chunks = $urandom_range(1, 3);
      span = chunk_span();
      start_pending = 1'b1;
      for (int c = 0; c < chunks; c++) begin
         last = span;
         if (c != 0 && c == chunks - 1 && $urandom_range(0, 1))
            last = HEADER_BYTES + 4 * $urandom_range(0, (span - HEADER_BYTES) / 4);
         fill_chunk(last, last);
      end
   endtask

   task automatic broken_walk();
      int unsigned span, pre, k, bad, namelen, first, head;
      logic [16:0] odd_chunk;
      start_pending = 1'b1;
      span = chunk_span();
      pre = 0;
      if (span >= 16 && $urandom_range(0, 1))
         pre = HEADER_BYTES + 4 * $urandom_range(0, (span - 16) / 4);
      case ($urandom_range(0, 5))
         0: begin
            odd_chunk = span + $urandom_range(1, 7);
            fill_chunk(span, odd_chunk);
            send_byte($urandom_range(0, 255), odd_chunk);
         end
         1: begin
            if (pre != 0) fill_chunk(pre, span);
            case ($urandom_range(0, 3))
               0: bad = $urandom_range(0, 7);
               1: bad = HEADER_BYTES + 4 * $urandom_range(0, 8) + $urandom_range(1, 3);
               2: bad = span - pre + 4 * $urandom_range(1, 4);
               default: bad = $urandom_range(0, 65535);
            endcase
            send_record(random_inode(), bad, $urandom_range(0, 255), $urandom_range(0, 255),
                        0, span);
         end
         2: begin
            if (pre != 0) fill_chunk(pre, span);
            k = (span - pre - HEADER_BYTES) / 4;
            if (k > 20) k = 20;
            bad = HEADER_BYTES + 4 * $urandom_range(0, k);
            namelen = bad - HEADER_BYTES + $urandom_range(1, 40);
            if (namelen > 255) namelen = 255;
            send_record(random_inode(), bad, namelen, $urandom_range(0, 255), 0, span);
         end
         3: begin
            case ($urandom_range(0, 4))
               0: odd_chunk = 17'd0;
               1: odd_chunk = 17'd65536;
               2: odd_chunk = 17'h1FFFF;
               3: odd_chunk = 17'd65535;
               default: odd_chunk = $urandom_range(0, 131071);
            endcase
            fill_chunk(HEADER_BYTES + 4 * $urandom_range(0, 10), odd_chunk);
         end
         4: begin
            first = HEADER_BYTES + 4 * $urandom_range(0, 2);
            head = first + HEADER_BYTES + 4 * $urandom_range(0, 20);
            fill_chunk(first, head);
            send_byte($urandom_range(0, 255), head);
            send_byte($urandom_range(0, 255), head);
            send_byte($urandom_range(0, 255), $urandom_range(1, first + 3));
            fill_chunk(span, span);
         end
         default: begin
            start_pending = $urandom_range(0, 1);
            repeat ($urandom_range(1, 16))
               send_byte($urandom_range(0, 255), $urandom_range(0, 200));
         end
      endcase
      repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255), span);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      bit ft;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      sb = new();
      idle_on = 1'b1;
      start_pending = 1'b0;
      parsed_beats = 0;
      target = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A named entry with padding, then a deleted entry whose name is skipped.
      start_pending = 1'b1;
      send_record(32'hFFFF_FFFF, 16'd12, 8'd3, 8'hFF, 4, 17'd24);
      send_record(32'h0, 16'd12, 8'd4, 8'h00, 4, 17'd24);
      // A zero chunk length counts as one byte, so the first header is cut short.
      start_pending = 1'b1;
      send_byte(8'hFF, 17'd0);
      send_byte(8'h00, 17'd0);
      start_pending = 1'b1;
      send_record(32'h1, 16'd6, 8'd0, 8'h01, 0, 17'h1FFFF);
      start_pending = 1'b1;
      send_record(32'h8000_0000, 16'd16, 8'd9, 8'h80, 0, 17'd16);
      settle();

      target = parsed_beats;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase != 0) begin
            ft = (phase == 1 || phase == 5) ? 1'b0 : (phase == 2) ? 1'b1 : $urandom_range(0, 1);
            csr_write_enable <= 1'b1;
            csr_write_data <= ft;
            @(posedge clock);
            csr_write_enable <= 1'b0;
            sb.filetype_on = ft;
         end
         idle_on = (phase != 2);
         target += 300;
         while (parsed_beats < target) begin
            if ($urandom_range(0, 4) == 0) broken_walk();
            else good_walk();
         end
         settle();
      end

      sb.check_leftovers();
      if (sb.mismatches == 0) begin
         $display("[directory_entry_stream_parser_core] OK");
      end else begin
         $display("[directory_entry_stream_parser_core] ERROR");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      stall = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_data);
         if (stall != 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall = idle_cycles();
         end
      end
   end

   initial begin
      #10000000;
      $display("[directory_entry_stream_parser_core] ERROR");
      $finish;
   end

endmodule
